/* rtl/spp_pkg.sv */
// Shared types and constants for the sphere point projection pipeline.
package spp_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQR_W     = 2 * DIFF_W;
    localparam int SUM_W     = SQR_W + 2;
    localparam int RAD_W     = 31;
    localparam int RSQ_W     = 2 * RAD_W;
    localparam int TOL_W     = 32;
    localparam int ROOT_W    = 51;
    localparam int SQRT_REM_W = 2 * ROOT_W;
    localparam int QUO_W     = 18;
    localparam int DIV_REM_W = ROOT_W + 1;
    localparam int NORM_W    = 18;
    localparam int PROD_W    = QUO_W + RAD_W;
    localparam int FRAC_W    = 16;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 160;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE = 3'd4;

    localparam logic [1:0] SIDE_INSIDE  = 2'd0;
    localparam logic [1:0] SIDE_OUTSIDE = 2'd1;
    localparam logic [1:0] SIDE_BAND    = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;
    localparam logic [TOL_W-1:0] TOL_RST    = 32'd4295;

    typedef struct packed {
        logic                   found;
        logic [1:0]             side;
        logic [2:0]             neg;
        logic [2:0][DIFF_W-1:0] ad;
    } t_tag;

endpackage

/* rtl/spp_front.sv */
// Front stages: offsets from the center, squares, squared length and side class.
module spp_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_vld,
    input  logic [2:0][spp_pkg::COORD_W-1:0]     i_q,
    input  logic [2:0][spp_pkg::COORD_W-1:0]     i_c,
    input  logic [spp_pkg::RAD_W-1:0]            i_radius,
    input  logic [spp_pkg::TOL_W-1:0]            i_tol,
    output logic                                 o_vld,
    output logic [spp_pkg::SUM_W-1:0]            o_sq,
    output spp_pkg::t_tag                        o_tag
);

    logic                                r_v1, r_v2, r_v3, r_v4;
    logic [2:0][spp_pkg::DIFF_W-1:0]     r_d;
    logic [spp_pkg::RSQ_W-1:0]           r_rsq;
    logic [2:0][spp_pkg::DIFF_W-1:0]     r_ad;
    logic [2:0]                          r_neg;
    logic [2:0][spp_pkg::DIFF_W-1:0]     r_ad_d;
    logic [2:0]                          r_neg_d;
    logic [2:0][spp_pkg::SQR_W-1:0]      r_sqr;
    logic [spp_pkg::SUM_W-1:0]           r_sq;
    spp_pkg::t_tag                       r_tag;

    logic [2:0][spp_pkg::DIFF_W-1:0]     n_d;
    logic [2:0][spp_pkg::DIFF_W-1:0]     n_ad;
    logic [spp_pkg::SUM_W-1:0]           n_sum;
    logic [spp_pkg::SUM_W:0]             n_lo_cmp;
    logic [spp_pkg::SUM_W:0]             n_hi_cmp;
    logic [1:0]                          n_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i]  = {i_q[i][spp_pkg::COORD_W-1], i_q[i]}
                    - {i_c[i][spp_pkg::COORD_W-1], i_c[i]};
            n_ad[i] = r_d[i][spp_pkg::DIFF_W-1] ? (~r_d[i] + 1'b1) : r_d[i];
        end
        n_sum = {2'b00, r_sqr[0]} + {2'b00, r_sqr[1]} + {2'b00, r_sqr[2]};
        n_lo_cmp = {1'b0, n_sum} + {{(spp_pkg::SUM_W+1-spp_pkg::TOL_W){1'b0}}, i_tol};
        n_hi_cmp = {{(spp_pkg::SUM_W+1-spp_pkg::RSQ_W){1'b0}}, r_rsq}
                 + {{(spp_pkg::SUM_W+1-spp_pkg::TOL_W){1'b0}}, i_tol};
        if (n_lo_cmp <= {{(spp_pkg::SUM_W+1-spp_pkg::RSQ_W){1'b0}}, r_rsq}) begin
            n_side = spp_pkg::SIDE_INSIDE;
        end else if (n_hi_cmp <= {1'b0, n_sum}) begin
            n_side = spp_pkg::SIDE_OUTSIDE;
        end else begin
            n_side = spp_pkg::SIDE_BAND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d     <= n_d;
            r_rsq   <= i_radius * i_radius;
            r_ad    <= n_ad;
            r_ad_d  <= r_ad;
            r_neg_d <= r_neg;
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_d[i][spp_pkg::DIFF_W-1];
                r_sqr[i] <= r_ad[i] * r_ad[i];
            end
            r_sq        <= n_sum;
            r_tag.found <= (n_sum != '0);
            r_tag.side  <= n_side;
            r_tag.neg   <= r_neg_d;
            r_tag.ad    <= r_ad_d;
        end
    end

    assign o_vld = r_v4;
    assign o_sq  = r_sq;
    assign o_tag = r_tag;

endmodule

/* rtl/spp_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module spp_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_vld,
    input  logic [spp_pkg::SUM_W-1:0]     i_sq,
    input  spp_pkg::t_tag                 i_tag,
    output logic                          o_vld,
    output logic [spp_pkg::ROOT_W-1:0]    o_len,
    output spp_pkg::t_tag                 o_tag
);

    localparam int N = spp_pkg::ROOT_W;

    logic [spp_pkg::SQRT_REM_W-1:0] w_rem  [0:N];
    logic [spp_pkg::ROOT_W-1:0]     w_root [0:N];
    spp_pkg::t_tag                  w_tag  [0:N];
    logic                           w_vld  [0:N];

    // radicand is the squared length scaled by 2^32
    assign w_rem[0]  = {{(spp_pkg::SQRT_REM_W-spp_pkg::SUM_W-32){1'b0}}, i_sq, 32'b0};
    assign w_root[0] = '0;
    assign w_tag[0]  = i_tag;
    assign w_vld[0]  = i_vld;

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam int B = N - 1 - k;
        logic [spp_pkg::SQRT_REM_W-1:0] trial;
        logic [spp_pkg::SQRT_REM_W-1:0] n_rem;
        logic [spp_pkg::ROOT_W-1:0]     n_root;
        logic [spp_pkg::SQRT_REM_W-1:0] r_rem;
        logic [spp_pkg::ROOT_W-1:0]     r_root;
        spp_pkg::t_tag                  r_tag;
        logic                           r_vld;

        always_comb begin
            trial = ({{(spp_pkg::SQRT_REM_W-spp_pkg::ROOT_W){1'b0}}, w_root[k]} << (B + 1))
                  | ({{(spp_pkg::SQRT_REM_W-1){1'b0}}, 1'b1} << (2 * B));
            if (w_rem[k] >= trial) begin
                n_rem  = w_rem[k] - trial;
                n_root = w_root[k] | ({{(spp_pkg::ROOT_W-1){1'b0}}, 1'b1} << B);
            end else begin
                n_rem  = w_rem[k];
                n_root = w_root[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_adv) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_tag  <= w_tag[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_tag[k+1]  = r_tag;
        assign w_vld[k+1]  = r_vld;
    end

    assign o_vld = w_vld[N];
    assign o_len = w_root[N];
    assign o_tag = w_tag[N];

endmodule

/* rtl/spp_div.sv */
// Three pipelined restoring dividers: normal magnitude = |d| * 2^32 / length.
module spp_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_vld,
    input  logic [spp_pkg::ROOT_W-1:0]          i_len,
    input  spp_pkg::t_tag                       i_tag,
    output logic                                o_vld,
    output logic [2:0][spp_pkg::QUO_W-1:0]      o_q,
    output spp_pkg::t_tag                       o_tag
);

    localparam int N = spp_pkg::QUO_W;

    logic [2:0][spp_pkg::DIV_REM_W-1:0] w_rem [0:N];
    logic [2:0][spp_pkg::QUO_W-1:0]     w_q   [0:N];
    logic [spp_pkg::ROOT_W-1:0]         w_len [0:N];
    spp_pkg::t_tag                      w_tag [0:N];
    logic                               w_vld [0:N];

    // quotient fits 18 bits, so start from the dividend shifted down by 18
    for (genvar i = 0; i < 3; i++) begin : g_init
        assign w_rem[0][i] = {{(spp_pkg::DIV_REM_W-spp_pkg::DIFF_W-14){1'b0}},
                              i_tag.ad[i], 14'b0};
    end
    assign w_q[0]   = '0;
    assign w_len[0] = i_len;
    assign w_tag[0] = i_tag;
    assign w_vld[0] = i_vld;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [2:0][spp_pkg::DIV_REM_W-1:0] n_rem;
        logic [2:0][spp_pkg::QUO_W-1:0]     n_q;
        logic [spp_pkg::DIV_REM_W-1:0]      shl;
        logic [2:0][spp_pkg::DIV_REM_W-1:0] r_rem;
        logic [2:0][spp_pkg::QUO_W-1:0]     r_q;
        logic [spp_pkg::ROOT_W-1:0]         r_len;
        spp_pkg::t_tag                      r_tag;
        logic                               r_vld;

        always_comb begin
            shl = '0;
            for (int i = 0; i < 3; i++) begin
                shl = {w_rem[k][i][spp_pkg::DIV_REM_W-2:0], 1'b0};
                if (shl >= {1'b0, w_len[k]}) begin
                    n_rem[i] = shl - {1'b0, w_len[k]};
                    n_q[i]   = {w_q[k][i][spp_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[i] = shl;
                    n_q[i]   = {w_q[k][i][spp_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_adv) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_len <= w_len[k];
                r_tag <= w_tag[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_q[k+1]   = r_q;
        assign w_len[k+1] = r_len;
        assign w_tag[k+1] = r_tag;
        assign w_vld[k+1] = r_vld;
    end

    assign o_vld = w_vld[N];
    assign o_q   = w_q[N];
    assign o_tag = w_tag[N];

endmodule

/* rtl/spp_back.sv */
// Back stages: scale the normal by the radius, offset by the center, saturate, pack.
module spp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_vld,
    input  logic [2:0][spp_pkg::QUO_W-1:0]      i_q,
    input  spp_pkg::t_tag                       i_tag,
    input  logic [2:0][spp_pkg::COORD_W-1:0]    i_c,
    input  logic [spp_pkg::RAD_W-1:0]           i_radius,
    output logic                                o_vld,
    output logic [spp_pkg::OUT_TDATA_W-1:0]     o_data
);

    localparam int OFF_W  = spp_pkg::PROD_W - spp_pkg::FRAC_W;
    localparam int NEAR_W = OFF_W + 2;

    logic                                r_v1, r_v2;
    logic [2:0][spp_pkg::PROD_W-1:0]     r_prod;
    logic [2:0][spp_pkg::QUO_W-1:0]      r_q;
    spp_pkg::t_tag                       r_tag;
    logic [spp_pkg::OUT_TDATA_W-1:0]     r_data;

    logic [2:0][OFF_W-1:0]               n_off;
    logic [2:0][NEAR_W-1:0]              n_near;
    logic [2:0][spp_pkg::COORD_W-1:0]    n_sat;
    logic [2:0][spp_pkg::NORM_W-1:0]     n_norm;
    logic [spp_pkg::OUT_TDATA_W-1:0]     n_data;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_off[i] = r_prod[i][spp_pkg::PROD_W-1:spp_pkg::FRAC_W];
            if (r_tag.neg[i]) begin
                n_near[i] = {{(NEAR_W-spp_pkg::COORD_W){i_c[i][spp_pkg::COORD_W-1]}}, i_c[i]}
                          - {2'b00, n_off[i]};
                n_norm[i] = ~r_q[i] + 1'b1;
            end else begin
                n_near[i] = {{(NEAR_W-spp_pkg::COORD_W){i_c[i][spp_pkg::COORD_W-1]}}, i_c[i]}
                          + {2'b00, n_off[i]};
                n_norm[i] = r_q[i];
            end
            // clamp to the 32-bit coordinate range
            if (!n_near[i][NEAR_W-1] &&
                (n_near[i][NEAR_W-2:spp_pkg::COORD_W-1] != '0)) begin
                n_sat[i] = {1'b0, {(spp_pkg::COORD_W-1){1'b1}}};
            end else if (n_near[i][NEAR_W-1] &&
                         (n_near[i][NEAR_W-2:spp_pkg::COORD_W-1] != '1)) begin
                n_sat[i] = {1'b1, {(spp_pkg::COORD_W-1){1'b0}}};
            end else begin
                n_sat[i] = n_near[i][spp_pkg::COORD_W-1:0];
            end
            if (!r_tag.found) begin
                n_sat[i]  = '0;
                n_norm[i] = '0;
            end
        end
        n_data = {7'b0, r_tag.side, r_tag.found, n_norm[2], n_norm[1], n_norm[0],
                  n_sat[2], n_sat[1], n_sat[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= i_q[i] * i_radius;
            end
            r_q    <= i_q;
            r_tag  <= i_tag;
            r_data <= n_data;
        end
    end

    assign o_vld  = r_v2;
    assign o_data = r_data;

endmodule

/* rtl/sphere_point_projection.sv */
// The pipeline has 75 register stages from input word accepted to result word valid;
// it takes one word per cycle unless the output stalls. The square root takes 51 stages,
// one root bit each; each of the three dividers takes 18 stages, one quotient bit each.
// A stall at the output holds the whole pipeline in place, bubbles included.
// Reset (synchronous, active low) clears all valid bits and loads the center to 0,
// the radius to 1.0 and the tolerance to 4295.
module sphere_point_projection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: query_x [31:0], query_y [63:32], query_z [95:64]
    input  logic [spp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: near_x [31:0], near_y [63:32], near_z [95:64], normal_x [113:96],
    //        normal_y [131:114], normal_z [149:132], found [150],
    //        side_class [152:151], zero [159:153]
    output logic [spp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [spp_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [spp_pkg::COORD_W-1:0]         i_cfg_data
);

    logic [2:0][spp_pkg::COORD_W-1:0]  r_center;
    logic [spp_pkg::RAD_W-1:0]         r_radius;
    logic [spp_pkg::TOL_W-1:0]         r_tol;

    logic                              w_adv;
    logic [2:0][spp_pkg::COORD_W-1:0]  w_q;

    logic                              w_f_vld, w_s_vld, w_d_vld;
    logic [spp_pkg::SUM_W-1:0]         w_sq;
    spp_pkg::t_tag                     w_f_tag, w_s_tag, w_d_tag;
    logic [spp_pkg::ROOT_W-1:0]        w_len;
    logic [2:0][spp_pkg::QUO_W-1:0]    w_quo;

    // configuration registers; out-of-range indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_radius <= spp_pkg::RADIUS_RST;
            r_tol    <= spp_pkg::TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                spp_pkg::REG_CENTER_X:  r_center[0] <= i_cfg_data;
                spp_pkg::REG_CENTER_Y:  r_center[1] <= i_cfg_data;
                spp_pkg::REG_CENTER_Z:  r_center[2] <= i_cfg_data;
                spp_pkg::REG_RADIUS:    r_radius    <= i_cfg_data[spp_pkg::RAD_W-1:0];
                spp_pkg::REG_TOLERANCE: r_tol       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance every stage whenever the output register is free or being drained
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    assign w_q[0] = s_axis_tdata[31:0];
    assign w_q[1] = s_axis_tdata[63:32];
    assign w_q[2] = s_axis_tdata[95:64];

    spp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (s_axis_tvalid),
        .i_q      (w_q),
        .i_c      (r_center),
        .i_radius (r_radius),
        .i_tol    (r_tol),
        .o_vld    (w_f_vld),
        .o_sq     (w_sq),
        .o_tag    (w_f_tag)
    );

    spp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_f_vld),
        .i_sq    (w_sq),
        .i_tag   (w_f_tag),
        .o_vld   (w_s_vld),
        .o_len   (w_len),
        .o_tag   (w_s_tag)
    );

    spp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_s_vld),
        .i_len   (w_len),
        .i_tag   (w_s_tag),
        .o_vld   (w_d_vld),
        .o_q     (w_quo),
        .o_tag   (w_d_tag)
    );

    spp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (w_d_vld),
        .i_q      (w_quo),
        .i_tag    (w_d_tag),
        .i_c      (r_center),
        .i_radius (r_radius),
        .o_vld    (m_axis_tvalid),
        .o_data   (m_axis_tdata)
    );

endmodule

/* rtl/spp_checker.sv */
// Port-level checks for the sphere point projection block, bound to the top level.
module spp_assertions (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [spp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_nofound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[150] |-> m_axis_tdata[149:0] == '0)
        else $error("point at center gave nonzero outputs");

    a_side_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[152:151] != 2'd3 && m_axis_tdata[159:153] == '0)
        else $error("bad side class or padding");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");

endmodule

bind sphere_point_projection spp_assertions u_spp_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
